// ----- hdl/assert_macros.svh -----
// assertion macros shared by the noise gate modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- hdl/ang_pkg.sv -----
// types and constants of the noise gate
`default_nettype none

package ang_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int GAIN_W     = 17;
    localparam int COEFF_W    = 16;
    localparam int THRESH_W   = 24;
    localparam int HOLD_W     = 23;
    localparam int COUNT_W    = 24;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 24;
    localparam int SPROD_W    = COEFF_W + GAIN_W;
    localparam int OPROD_W    = SAMPLE_W + GAIN_W + 1;

    localparam logic [GAIN_W-1:0]  GAIN_ONE  = 17'h10000;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 24'hFFFFFF;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD     = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_COEFF  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_COEFF = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_SAMPLES  = 8'd3;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic mult;
        logic update;
        logic emit;
    } t_dp_cmd;

endpackage

`default_nettype wire

// ----- hdl/ang_datapath.sv -----
// datapath: configuration registers, gain and hold state, multipliers, output register
`default_nettype none
`include "assert_macros.svh"

module ang_datapath (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire ang_pkg::t_dp_cmd                i_cmd,
    input  wire signed [ang_pkg::SAMPLE_W-1:0]   i_sample_in,
    input  wire                                  i_cfg_valid,
    input  wire        [ang_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire        [ang_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                                 o_cfg_ready,
    output logic signed [ang_pkg::SAMPLE_W-1:0]  o_sample_out,
    output logic       [ang_pkg::GAIN_W-1:0]     o_gain_now
);

    typedef enum logic [1:0] {
        M_HOLD,
        M_ATTACK,
        M_RELEASE
    } t_mode;

    logic        [ang_pkg::THRESH_W-1:0] r_threshold;
    logic        [ang_pkg::COEFF_W-1:0]  r_attack_coeff;
    logic        [ang_pkg::COEFF_W-1:0]  r_release_coeff;
    logic        [ang_pkg::HOLD_W-1:0]   r_hold_samples;

    logic        [ang_pkg::GAIN_W-1:0]   r_gain;
    logic        [ang_pkg::COUNT_W-1:0]  r_hold_count;

    logic signed [ang_pkg::SAMPLE_W-1:0] r_sample;
    logic        [ang_pkg::COEFF_W-1:0]  r_coeff;
    logic                                r_open;
    t_mode                               r_mode;
    logic        [ang_pkg::SPROD_W-1:0]  r_prod;

    logic        [ang_pkg::SAMPLE_W-1:0] w_mag;
    logic                                w_open;
    logic                                w_attack;
    t_mode                               w_mode;
    logic        [ang_pkg::GAIN_W-1:0]   w_gain_new;
    logic        [ang_pkg::GAIN_W-1:0]   w_offset;
    logic signed [ang_pkg::OPROD_W-1:0]  w_out_prod;

    assign o_cfg_ready = 1'b1;

    // full-scale negative maps to 2^23, which still fits unsigned
    assign w_mag    = i_sample_in[ang_pkg::SAMPLE_W-1]
                    ? (~i_sample_in + 24'd1) : i_sample_in;
    assign w_open   = (w_mag >= r_threshold);
    assign w_attack = !w_open || (r_gain == ang_pkg::GAIN_ONE);

    always_comb begin
        if (!w_attack) begin
            w_mode = M_RELEASE;
        end else if (r_hold_count > {1'b0, r_hold_samples}) begin
            w_mode = M_ATTACK;
        end else begin
            w_mode = M_HOLD;
        end
    end

    // smoothing with target 1.0 adds (1 - c) exactly
    assign w_offset   = r_open ? (ang_pkg::GAIN_ONE - {1'b0, r_coeff}) : '0;
    assign w_gain_new = r_prod[ang_pkg::SPROD_W-1:16] + w_offset;

    assign w_out_prod =
        $signed({{(ang_pkg::OPROD_W-ang_pkg::SAMPLE_W){r_sample[ang_pkg::SAMPLE_W-1]}},
                 r_sample})
        * $signed({{(ang_pkg::OPROD_W-ang_pkg::GAIN_W){1'b0}}, r_gain});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold     <= '0;
            r_attack_coeff  <= '0;
            r_release_coeff <= '0;
            r_hold_samples  <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                ang_pkg::CFG_THRESHOLD:     r_threshold     <= i_cfg_data[23:0];
                ang_pkg::CFG_ATTACK_COEFF:  r_attack_coeff  <= i_cfg_data[15:0];
                ang_pkg::CFG_RELEASE_COEFF: r_release_coeff <= i_cfg_data[15:0];
                ang_pkg::CFG_HOLD_SAMPLES:  r_hold_samples  <= i_cfg_data[22:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain       <= '0;
            r_hold_count <= '0;
        end else if (i_cmd.update) begin
            case (r_mode)
                M_ATTACK: begin
                    r_gain <= w_gain_new;
                end
                M_RELEASE: begin
                    r_gain       <= w_gain_new;
                    r_hold_count <= '0;
                end
                M_HOLD: begin
                    if (r_hold_count != ang_pkg::COUNT_MAX) begin
                        r_hold_count <= r_hold_count + 24'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sample <= i_sample_in;
            r_open   <= w_open;
            r_mode   <= w_mode;
            r_coeff  <= (w_mode == M_RELEASE) ? r_release_coeff : r_attack_coeff;
        end
        if (i_cmd.mult) begin
            r_prod <= {{ang_pkg::GAIN_W{1'b0}}, r_coeff} * {{ang_pkg::COEFF_W{1'b0}}, r_gain};
        end
        if (i_cmd.emit) begin
            o_sample_out <= w_out_prod[39:16];
            o_gain_now   <= r_gain;
        end
    end

    `ASSERT_IMPL(a_gain_range, i_clk, i_rst_n, 1'b1, r_gain <= ang_pkg::GAIN_ONE)
    `ASSERT_NEXT(a_release_clears, i_clk, i_rst_n, i_cmd.update && r_mode == M_RELEASE, r_hold_count == '0)
    `ASSERT_NEXT(a_hold_keeps_gain, i_clk, i_rst_n, i_cmd.update && r_mode == M_HOLD, $stable(r_gain))

endmodule

`default_nettype wire

// ----- hdl/ang_ctrl.sv -----
// controller: sequences load, smoothing multiply, gain update and output
`default_nettype none
`include "assert_macros.svh"

module ang_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  wire               i_out_ready,
    output ang_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MULT,
        S_UPDATE,
        S_OUTPUT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd.load   = (r_state == S_IDLE) && i_in_valid;
        o_cmd.mult   = (r_state == S_MULT);
        o_cmd.update = (r_state == S_UPDATE);
        // result register must be empty or draining this cycle
        o_cmd.emit   = (r_state == S_OUTPUT) && (!r_out_valid || i_out_ready);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (o_cmd.load) n_state = S_MULT;
            S_MULT:   n_state = S_UPDATE;
            S_UPDATE: n_state = S_OUTPUT;
            S_OUTPUT: if (o_cmd.emit) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
        if (o_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    `ASSERT_IMPL(a_emit_free, i_clk, i_rst_n, o_cmd.emit, !r_out_valid || i_out_ready)
    `ASSERT_NEXT(a_load_starts, i_clk, i_rst_n, i_in_valid && o_in_ready, r_state == S_MULT)
    `ASSERT_NEXT(a_emit_valid, i_clk, i_rst_n, o_cmd.emit, r_out_valid && r_state == S_IDLE)

endmodule

`default_nettype wire

// ----- hdl/audio_noise_gate_unit.sv -----
// top level of the audio noise gate
`default_nettype none

// Noise gate with hold, attack and release smoothing. A sample is accepted
// only while the gate is idle; it then passes through accept and gate
// decision, smoothing multiply, gain and hold update and output multiply,
// and no new sample is taken before the last one has written its result.
// The two dependent multiplies, coefficient by gain and sample by new gain,
// set that order of steps. The result register lets a new sample
// be accepted while the previous result still waits. Configuration writes
// are always accepted and are meant to happen while no sample is in flight.
// Register indexes: 0 threshold, 1 attack coefficient, 2 release
// coefficient, 3 hold length; other indexes are ignored.

module audio_noise_gate_unit (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_in_valid,
    output logic                                 o_in_ready,
    input  wire signed [ang_pkg::SAMPLE_W-1:0]   i_sample_in,
    output logic                                 o_out_valid,
    input  wire                                  i_out_ready,
    output logic signed [ang_pkg::SAMPLE_W-1:0]  o_sample_out,
    output logic       [ang_pkg::GAIN_W-1:0]     o_gain_now,
    input  wire                                  i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire        [ang_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire        [ang_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    ang_pkg::t_dp_cmd w_cmd;

    ang_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd)
    );

    ang_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_sample_in  (i_sample_in),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_cfg_ready  (o_cfg_ready),
        .o_sample_out (o_sample_out),
        .o_gain_now   (o_gain_now)
    );

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// self-checking testbench for the audio noise gate unit
`timescale 1ns / 100ps

module testbench;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int STALL_CYCLES = 300;
    localparam int DRAIN_CYCLES = 12;
    localparam int RAND_PHASES  = 8;
    localparam int PHASE_ITEMS  = 150;
    localparam int FULL_SCALE   = 8388608;

    // indexes the block must ignore
    localparam logic [ang_pkg::CFG_IDX_W-1:0] CFG_UNUSED_LO = 8'd4;
    localparam logic [ang_pkg::CFG_IDX_W-1:0] CFG_UNUSED_HI = 8'hFF;

    typedef struct {
        logic [ang_pkg::SAMPLE_W-1:0] sample;
        logic [ang_pkg::GAIN_W-1:0]   gain;
    } t_gated;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic                                drv_valid = 1'b0;
    logic signed [ang_pkg::SAMPLE_W-1:0] drv_sample = '0;
    logic                                mon_ready = 1'b0;
    logic                                cfg_valid = 1'b0;
    logic [ang_pkg::CFG_IDX_W-1:0]       cfg_index = '0;
    logic [ang_pkg::CFG_DATA_W-1:0]      cfg_data = '0;

    wire                                 o_in_ready;
    wire                                 o_out_valid;
    wire signed [ang_pkg::SAMPLE_W-1:0]  o_sample_out;
    wire [ang_pkg::GAIN_W-1:0]           o_gain_now;
    wire                                 o_cfg_ready;

    // gate state and registers as the block should hold them
    logic [ang_pkg::THRESH_W-1:0] m_thr = '0;
    logic [ang_pkg::COEFF_W-1:0]  m_atk = '0;
    logic [ang_pkg::COEFF_W-1:0]  m_rel = '0;
    logic [ang_pkg::HOLD_W-1:0]   m_hold_len = '0;
    logic [ang_pkg::GAIN_W-1:0]   m_gain = '0;
    logic [ang_pkg::COUNT_W-1:0]  m_hold = '0;

    logic signed [ang_pkg::SAMPLE_W-1:0] pending[$];
    t_gated                              expected_out[$];
    t_gated                              mon_exp;

    int  cycles = 0;
    int  err_count = 0;
    int  n_sent = 0;
    int  n_checked = 0;
    int  n_cfg = 0;
    int  n_settings = 0;
    int  in_gap = 0;
    int  out_gap = 0;
    int  stall_requests = 0;
    int  stall_served = 0;
    int  stall_left = 0;
    bit  idle_on = 1'b1;

    audio_noise_gate_unit i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (drv_valid),
        .o_in_ready   (o_in_ready),
        .i_sample_in  (drv_sample),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (mon_ready),
        .o_sample_out (o_sample_out),
        .o_gain_now   (o_gain_now),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic logic [ang_pkg::GAIN_W-1:0] smooth_gain(
            input logic [ang_pkg::COEFF_W-1:0] c,
            input logic [ang_pkg::GAIN_W-1:0] g,
            input logic [ang_pkg::GAIN_W-1:0] t);
        longint unsigned cc, gg, tt, one, acc;
        cc  = c;
        gg  = g;
        tt  = t;
        one = ang_pkg::GAIN_ONE;
        acc = cc * gg + (one - cc) * tt;
        return acc[16 +: ang_pkg::GAIN_W];
    endfunction

    // advances the gate state by one sample and returns the gated output
    function automatic t_gated gate_predict(input logic signed [ang_pkg::SAMPLE_W-1:0] s);
        logic [ang_pkg::SAMPLE_W-1:0] mag;
        logic [ang_pkg::GAIN_W-1:0]   target;
        longint                       s64, g64, prod;
        t_gated                       r;
        mag    = s[ang_pkg::SAMPLE_W-1] ? -s : s;
        target = (mag < m_thr) ? '0 : ang_pkg::GAIN_ONE;
        if (target <= m_gain) begin
            if (m_hold > m_hold_len) begin
                m_gain = smooth_gain(m_atk, m_gain, target);
            end else if (m_hold < ang_pkg::COUNT_MAX) begin
                m_hold = m_hold + 1'b1;
            end
        end else begin
            m_gain = smooth_gain(m_rel, m_gain, target);
            m_hold = '0;
        end
        s64  = s;
        g64  = m_gain;
        prod = s64 * g64;
        // low bits of the arithmetic shift give floor for negative products
        r.sample = prod[16 +: ang_pkg::SAMPLE_W];
        r.gain   = m_gain;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        if (err_count < 40) $display("mismatch at cycle %0d: %s", cycles, msg);
        err_count++;
    endtask

    task automatic cfg_write(input logic [ang_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ang_pkg::CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        n_cfg++;
        case (idx)
            ang_pkg::CFG_THRESHOLD:     m_thr      = val[ang_pkg::THRESH_W-1:0];
            ang_pkg::CFG_ATTACK_COEFF:  m_atk      = val[ang_pkg::COEFF_W-1:0];
            ang_pkg::CFG_RELEASE_COEFF: m_rel      = val[ang_pkg::COEFF_W-1:0];
            ang_pkg::CFG_HOLD_SAMPLES:  m_hold_len = val[ang_pkg::HOLD_W-1:0];
            default: ;
        endcase
    endtask

    task automatic send(input int v);
        pending.push_back(v[ang_pkg::SAMPLE_W-1:0]);
    endtask

    // waits until every queued sample has come back, then lets the pipe settle
    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending.size() != 0 || drv_valid || expected_out.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        n_settings++;
    endtask

    function automatic int unsigned pick_mag(input bit loud);
        int unsigned t, top;
        t = m_thr;
        if (loud) begin
            if (t > FULL_SCALE) return $urandom_range(0, FULL_SCALE);
            top = (t + 255 > FULL_SCALE) ? FULL_SCALE : t + 255;
            if ($urandom_range(0, 3) == 0) return $urandom_range(t, top);
            return $urandom_range(t, FULL_SCALE);
        end
        if (t == 0) return 0;
        top = (t > FULL_SCALE) ? FULL_SCALE : t - 1;
        if ($urandom_range(0, 3) == 0) return (top > 255) ? $urandom_range(top - 255, top) : top;
        return $urandom_range(0, top);
    endfunction

    function automatic logic signed [ang_pkg::SAMPLE_W-1:0] signed_from_mag(
            input int unsigned mag);
        int v;
        if ($urandom_range(0, 1) == 1) begin
            v = -int'(mag);
        end else begin
            v = (mag > FULL_SCALE - 1) ? FULL_SCALE - 1 : int'(mag);
        end
        return v[ang_pkg::SAMPLE_W-1:0];
    endfunction

    // sample channel driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            drv_valid <= 1'b0;
        end else begin
            if (drv_valid && o_in_ready) begin
                expected_out.push_back(gate_predict(drv_sample));
                n_sent++;
            end
            if (!drv_valid || o_in_ready) begin
                if (in_gap > 0) begin
                    in_gap--;
                    drv_valid <= 1'b0;
                end else if (pending.size() != 0) begin
                    drv_sample <= pending.pop_front();
                    drv_valid  <= 1'b1;
                    if (idle_on && $urandom_range(0, 4) == 0) in_gap = $urandom_range(1, 6);
                end else begin
                    drv_valid <= 1'b0;
                end
            end
        end
    end

    // result channel monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mon_ready <= 1'b0;
        end else begin
            if (o_out_valid && mon_ready) begin
                if (expected_out.size() == 0) begin
                    report_mismatch($sformatf("unexpected result sample %h gain %h",
                                              o_sample_out, o_gain_now));
                end else begin
                    mon_exp = expected_out.pop_front();
                    if (o_sample_out !== mon_exp.sample)
                        report_mismatch($sformatf("sample_out %h, expected %h",
                                                  o_sample_out, mon_exp.sample));
                    if (o_gain_now !== mon_exp.gain)
                        report_mismatch($sformatf("gain_now %h, expected %h",
                                                  o_gain_now, mon_exp.gain));
                    n_checked++;
                end
            end
            if (stall_served != stall_requests) begin
                stall_served = stall_requests;
                stall_left   = STALL_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                mon_ready <= 1'b0;
            end else if (out_gap > 0) begin
                out_gap--;
                mon_ready <= 1'b0;
            end else begin
                mon_ready <= 1'b1;
                if (idle_on && $urandom_range(0, 5) == 0) out_gap = $urandom_range(1, 6);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, expected_out.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin : stim
        int unsigned thr_v, atk_v, rel_v, hold_v, mag;
        int          count, burst, quiet, k;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // registers at reset: zero threshold keeps the gate open, zero release jumps to unity
        send(0);
        send(FULL_SCALE - 1);
        send(-FULL_SCALE);
        send(-1);
        send(1);
        wait_drained();

        // around the threshold, through hold into attack and back to release
        cfg_write(ang_pkg::CFG_THRESHOLD, 24'h100000);
        cfg_write(ang_pkg::CFG_ATTACK_COEFF, 24'h008000);
        cfg_write(ang_pkg::CFG_RELEASE_COEFF, 24'h004000);
        cfg_write(ang_pkg::CFG_HOLD_SAMPLES, 24'h000002);
        cfg_write(CFG_UNUSED_HI, 24'hFFFFFF);
        cfg_write(CFG_UNUSED_LO, 24'h123456);
        send(24'h100000);
        send(FULL_SCALE - 1);
        send(-FULL_SCALE);
        send(24'h0FFFFF);
        send(-24'h0FFFFF);
        send(0);
        send(1);
        send(-1);
        send(5);
        send(-24'h100000);
        send(FULL_SCALE - 1);
        send(-FULL_SCALE);
        wait_drained();

        // threshold above full scale, register bits above width set
        cfg_write(ang_pkg::CFG_THRESHOLD, 24'h800001);
        cfg_write(ang_pkg::CFG_ATTACK_COEFF, 24'hFFFFFF);
        cfg_write(ang_pkg::CFG_RELEASE_COEFF, 24'hFF0000);
        cfg_write(ang_pkg::CFG_HOLD_SAMPLES, 24'hFFFFFF);
        send(-FULL_SCALE);
        send(FULL_SCALE - 1);
        send(0);
        send(100);
        wait_drained();

        // threshold at full scale: only the most negative sample opens the gate
        cfg_write(ang_pkg::CFG_THRESHOLD, 24'h800000);
        cfg_write(ang_pkg::CFG_HOLD_SAMPLES, 24'h000000);
        cfg_write(ang_pkg::CFG_ATTACK_COEFF, 24'h000000);
        send(FULL_SCALE - 1);
        send(FULL_SCALE - 1);
        send(-FULL_SCALE);
        send(-(FULL_SCALE - 1));
        wait_drained();

        for (int p = 0; p < RAND_PHASES; p++) begin
            case ($urandom_range(0, 7))
                0:       thr_v = 0;
                1:       thr_v = FULL_SCALE;
                2:       thr_v = FULL_SCALE + 1 + $urandom_range(0, 255);
                3, 4:    thr_v = $urandom_range(1, FULL_SCALE - 1);
                5, 6:    thr_v = $urandom_range(1, 24'h03FFFF);
                default: thr_v = $urandom & 24'hFFFFFF;
            endcase
            case ($urandom_range(0, 4))
                0:       atk_v = 0;
                1:       atk_v = 16'hFFFF;
                2:       atk_v = $urandom & 24'hFFFFFF;
                default: atk_v = $urandom_range(0, 16'hFFFF);
            endcase
            case ($urandom_range(0, 4))
                0:       rel_v = 0;
                1:       rel_v = 16'hFFFF;
                2:       rel_v = $urandom & 24'hFFFFFF;
                default: rel_v = $urandom_range(0, 16'hFFFF);
            endcase
            case ($urandom_range(0, 7))
                0:       hold_v = 0;
                1:       hold_v = 23'h7FFFFF;
                2:       hold_v = $urandom & 24'hFFFFFF;
                default: hold_v = $urandom_range(0, 24);
            endcase
            cfg_write(ang_pkg::CFG_THRESHOLD, thr_v[ang_pkg::CFG_DATA_W-1:0]);
            cfg_write(ang_pkg::CFG_ATTACK_COEFF, atk_v[ang_pkg::CFG_DATA_W-1:0]);
            cfg_write(ang_pkg::CFG_RELEASE_COEFF, rel_v[ang_pkg::CFG_DATA_W-1:0]);
            cfg_write(ang_pkg::CFG_HOLD_SAMPLES, hold_v[ang_pkg::CFG_DATA_W-1:0]);

            // the closing phase runs with both sides always ready
            idle_on = (p < RAND_PHASES - 1);
            count = 0;
            while (count < PHASE_ITEMS) begin
                k = $urandom_range(0, 9);
                if (k < 7) begin
                    // loud burst, then a quiet stretch of random length that may or may not pass the hold
                    burst = $urandom_range(1, 8);
                    quiet = $urandom_range(1, (m_hold_len < 32) ? int'(m_hold_len) + 8 : 40);
                    repeat (burst) pending.push_back(signed_from_mag(pick_mag(1'b1)));
                    repeat (quiet) pending.push_back(signed_from_mag(pick_mag(1'b0)));
                    count += burst + quiet;
                end else if (k < 9) begin
                    mag = $urandom;
                    pending.push_back(mag[ang_pkg::SAMPLE_W-1:0]);
                    count++;
                end else begin
                    mag = (m_thr > FULL_SCALE) ? FULL_SCALE : m_thr;
                    pending.push_back(signed_from_mag(mag));
                    pending.push_back(signed_from_mag((mag > 0) ? mag - 1 : 0));
                    count += 2;
                end
            end
            if (p == 3) begin
                // receiver holds off while the sender keeps offering
                @(negedge i_clk);
                stall_requests++;
            end
            wait_drained();
        end

        $display("covered %0d samples over %0d register settings, %0d register writes",
                 n_sent, n_settings, n_cfg);
        $display("checked %0d results, including a long receiver stall", n_checked);
        if (err_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches", err_count);
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
